// File: rtl/pit_pkg.sv
// shared types and constants for the proximity interaction tracker
// no dependencies; imported by every module in rtl/
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

    localparam int DIST_W         = 16;
    localparam int COUNT_W        = 16;
    localparam int KEPT_DISTANCES = 4;
    localparam int CFG_IDX_W      = 2;

    typedef logic [DIST_W-1:0]    dist_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam dist_t  EMPTY_DIST = '1;
    localparam count_t COUNT_MAX  = '1;

    localparam dist_t JUST_RIGHT_MIN_RST   = 16'd12;
    localparam dist_t TOO_FAR_MIN_RST      = 16'd48;
    localparam dist_t OUT_OF_RANGE_MIN_RST = 16'd120;

    typedef enum logic [1:0] {
        ZONE_TOO_CLOSE    = 2'd0,
        ZONE_JUST_RIGHT   = 2'd1,
        ZONE_TOO_FAR      = 2'd2,
        ZONE_OUT_OF_RANGE = 2'd3
    } zone_t;

    localparam cfg_idx_t CFG_JUST_RIGHT_MIN   = 2'd0;
    localparam cfg_idx_t CFG_TOO_FAR_MIN      = 2'd1;
    localparam cfg_idx_t CFG_OUT_OF_RANGE_MIN = 2'd2;

    typedef struct packed {
        logic  en;
        dist_t value;
    } insert_req_t;

endpackage

`default_nettype wire

// File: rtl/pit_classify.sv
// zone classifier: three threshold compares in priority order
// depends on pit_pkg
`timescale 1ns / 1ps
`default_nettype none

module pit_classify (
    input  pit_pkg::dist_t distance,
    input  pit_pkg::dist_t just_right_min,
    input  pit_pkg::dist_t too_far_min,
    input  pit_pkg::dist_t out_of_range_min,
    output pit_pkg::zone_t zone
);
    import pit_pkg::*;

    always_comb
    begin
        if (distance >= out_of_range_min)
        begin
            zone = ZONE_OUT_OF_RANGE;
        end
        else if (distance >= too_far_min)
        begin
            zone = ZONE_TOO_FAR;
        end
        else if (distance >= just_right_min)
        begin
            zone = ZONE_JUST_RIGHT;
        end
        else
        begin
            zone = ZONE_TOO_CLOSE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pit_nearest.sv
// ascending list of the smallest unsafe distances with a registered sorted insert
// depends on pit_pkg
`timescale 1ns / 1ps
`default_nettype none

module pit_nearest (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pit_pkg::insert_req_t req,
    output pit_pkg::dist_t       nearest [pit_pkg::KEPT_DISTANCES]
);
    import pit_pkg::*;

    dist_t list_reg  [KEPT_DISTANCES];
    dist_t list_next [KEPT_DISTANCES];

    always_comb
    begin
        logic  placed;
        dist_t carry;
        placed = 1'b0;
        carry  = EMPTY_DIST;
        for (int i = 0; i < KEPT_DISTANCES; i++)
        begin
            list_next[i] = list_reg[i];
            if (req.en)
            begin
                if (!placed && (req.value < list_reg[i]))
                begin
                    placed       = 1'b1;
                    carry        = list_reg[i];
                    list_next[i] = req.value;
                end
                else if (placed)
                begin
                    list_next[i] = carry;
                    carry        = list_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEPT_DISTANCES; i++)
            begin
                list_reg[i] <= EMPTY_DIST;
            end
        end
        else
        begin
            for (int i = 0; i < KEPT_DISTANCES; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
    end

    assign nearest = list_reg;

endmodule

`default_nettype wire

// File: rtl/proximity_interaction_tracker.sv
// proximity interaction tracker top level: input register, tracking state, result hold
// depends on pit_pkg, pit_classify, pit_nearest
//
// usage
//   input channel: in_valid / in_stall with one 16-bit distance sample per transfer
//   output channel: out_valid / out_stall; result fields are zone, interacting,
//   interaction_total, unsafe_total and nearest_0..nearest_3
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, index 0 just_right_min, 1 too_far_min, 2 out_of_range_min, 3 ignored
//   processing: an accepted sample waits in the input register and is processed into
//   the result registers once the output slot is free
//   throughput: one sample per cycle while the output is not stalled
//   the result fields are the tracking state registers themselves, so they only
//   change when a sample is processed into the result slot
//   out_stall: the result holds; one more sample waits in the input register,
//   after which in_stall rises until the result is taken
//   reset: thresholds 12 / 48 / 120, zone out of range, counters zero,
//   nearest list all 65535, both channels empty
`timescale 1ns / 1ps
`default_nettype none

module proximity_interaction_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pit_pkg::dist_t      distance,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          zone,
    output logic                interacting,
    output pit_pkg::count_t     interaction_total,
    output pit_pkg::count_t     unsafe_total,
    output pit_pkg::dist_t      nearest_0,
    output pit_pkg::dist_t      nearest_1,
    output pit_pkg::dist_t      nearest_2,
    output pit_pkg::dist_t      nearest_3,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pit_pkg::cfg_idx_t   cfg_index,
    input  pit_pkg::dist_t      cfg_data
);
    import pit_pkg::*;

    dist_t just_right_min_reg;
    dist_t too_far_min_reg;
    dist_t out_of_range_min_reg;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    dist_t s1_dist_reg;
    logic  out_valid_reg;
    logic  out_valid_next;

    zone_t  zone_reg;
    zone_t  zone_next;
    logic   in_progress_reg;
    logic   in_progress_next;
    logic   unsafe_reg;
    logic   unsafe_next;
    dist_t  running_min_reg;
    dist_t  running_min_next;
    count_t started_reg;
    count_t started_next;
    count_t unsafe_cnt_reg;
    count_t unsafe_cnt_next;

    zone_t       sample_zone;
    dist_t       min_base;
    logic        out_free;
    logic        go;
    logic        accept_in;
    insert_req_t ins_req;
    dist_t       nearest [KEPT_DISTANCES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            just_right_min_reg   <= JUST_RIGHT_MIN_RST;
            too_far_min_reg      <= TOO_FAR_MIN_RST;
            out_of_range_min_reg <= OUT_OF_RANGE_MIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_JUST_RIGHT_MIN:   just_right_min_reg   <= cfg_data;
                CFG_TOO_FAR_MIN:      too_far_min_reg      <= cfg_data;
                CFG_OUT_OF_RANGE_MIN: out_of_range_min_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign go        = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    pit_classify u_classify (
        .distance         (s1_dist_reg),
        .just_right_min   (just_right_min_reg),
        .too_far_min      (too_far_min_reg),
        .out_of_range_min (out_of_range_min_reg),
        .zone             (sample_zone)
    );

    // tracking update for the sample in the input register
    always_comb
    begin
        zone_next        = zone_reg;
        in_progress_next = in_progress_reg;
        unsafe_next      = unsafe_reg;
        started_next     = started_reg;
        unsafe_cnt_next  = unsafe_cnt_reg;
        running_min_next = running_min_reg;
        min_base         = running_min_reg;
        ins_req.en       = 1'b0;
        ins_req.value    = running_min_reg;

        if (go)
        begin
            zone_next = sample_zone;
            if (sample_zone inside {ZONE_TOO_CLOSE, ZONE_JUST_RIGHT})
            begin
                if ((zone_reg inside {ZONE_TOO_FAR, ZONE_OUT_OF_RANGE}) && !in_progress_reg)
                begin
                    in_progress_next = 1'b1;
                    if (started_reg != COUNT_MAX)
                    begin
                        started_next = started_reg + 1'b1;
                    end
                end
                if ((sample_zone == ZONE_TOO_CLOSE) && !unsafe_reg)
                begin
                    unsafe_next = 1'b1;
                    if (unsafe_cnt_reg != COUNT_MAX)
                    begin
                        unsafe_cnt_next = unsafe_cnt_reg + 1'b1;
                    end
                end
            end
            else if ((zone_reg inside {ZONE_TOO_CLOSE, ZONE_JUST_RIGHT}) && in_progress_reg)
            begin
                ins_req.en       = unsafe_reg;
                zone_next        = ZONE_OUT_OF_RANGE;
                min_base         = EMPTY_DIST;
                unsafe_next      = 1'b0;
                in_progress_next = 1'b0;
            end
            running_min_next = (s1_dist_reg < min_base) ? s1_dist_reg : min_base;
        end
    end

    pit_nearest u_nearest (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ins_req),
        .nearest (nearest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            zone_reg        <= ZONE_OUT_OF_RANGE;
            in_progress_reg <= 1'b0;
            unsafe_reg      <= 1'b0;
            running_min_reg <= EMPTY_DIST;
            started_reg     <= '0;
            unsafe_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            zone_reg        <= zone_next;
            in_progress_reg <= in_progress_next;
            unsafe_reg      <= unsafe_next;
            running_min_reg <= running_min_next;
            started_reg     <= started_next;
            unsafe_cnt_reg  <= unsafe_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_dist_reg <= distance;
        end
    end

    assign out_valid         = out_valid_reg;
    assign zone              = zone_reg;
    assign interacting       = in_progress_reg;
    assign interaction_total = started_reg;
    assign unsafe_total      = unsafe_cnt_reg;

    // fields past the end of a short list read as empty
    dist_t nearest_out [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_nearest
        if (k < KEPT_DISTANCES)
        begin : g_kept
            assign nearest_out[k] = nearest[k];
        end
        else
        begin : g_empty
            assign nearest_out[k] = EMPTY_DIST;
        end
    end

    assign nearest_0 = nearest_out[0];
    assign nearest_1 = nearest_out[1];
    assign nearest_2 = nearest_out[2];
    assign nearest_3 = nearest_out[3];

endmodule

`default_nettype wire
